// ===== rtl/wkvcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the WKV channel recurrence.
// No dependencies; imported by the sigmoid ROM, the datapath and the top level.
package wkvcr_pkg;

   // Default channel count for the top level
   localparam int CHANNELS_DEFAULT = 64;

   // Field widths
   localparam int STATE_W = 40;
   localparam int COEF_W  = 16;
   localparam int SIG_W   = 16;
   localparam int SIG_AW  = 10;
   localparam int SIG_DEPTH = 1 << SIG_AW;
   localparam int SIG_HALF  = SIG_DEPTH / 2;

   // Reset contents of the coefficient store
   localparam logic [COEF_W-1:0] DECAY_RESET = 16'd65096;
   localparam logic [COEF_W-1:0] BONUS_RESET = 16'd0;

   // Saturation bounds, 40-bit two's complement
   localparam logic [STATE_W-1:0] SAT_MAX = 40'h7F_FFFF_FFFF;
   localparam logic [STATE_W-1:0] SAT_MIN = 40'h80_0000_0000;

   // Command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_WKV,
      ST_GATE,
      ST_OUT
   } state_type;

   // Stage enables from the sequencer to the datapath
   typedef struct packed {
      logic capture;
      logic mul;
      logic sum;
      logic wkv;
      logic gate;
   } dp_ctl_type;

   typedef struct packed {
      logic               clip;
      logic [STATE_W-1:0] val;
   } sat_type;

   typedef logic [SIG_W-1:0] sig_rom_type [SIG_DEPTH];

   // Clip a 42-bit signed sum to 40 bits
   function automatic sat_type sat40(input logic [STATE_W+1:0] x);
      sat_type r;
      r.clip = !((x[STATE_W+1:STATE_W-1] == 3'b000) || (x[STATE_W+1:STATE_W-1] == 3'b111));
      if (r.clip) begin
         r.val = x[STATE_W+1] ? SAT_MIN : SAT_MAX;
      end else begin
         r.val = x[STATE_W-1:0];
      end
      return r;
   endfunction

   // Q62 product of two values no larger than one, truncated
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // Restoring long division, only evaluated while the table is built
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      int          i;
      quo = '0;
      rem = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Sigmoid table, evaluated at elaboration with fixed-point exp(-1/64) powers.
   // Lower half holds positive indices, upper half the negative ones.
   function automatic sig_rom_type sig_rom_fill();
      sig_rom_type rom;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] q;
      logic [63:0] q2;
      logic [63:0] e;
      logic [63:0] e42;
      logic [63:0] d;
      logic [63:0] np;
      logic [63:0] nn;
      logic [63:0] quo;
      int n;
      int j;
      rom  = '{default: '0};
      term = 64'd1 << 62;
      pos  = 64'd1 << 62;
      neg  = 64'd0;
      for (n = 1; n <= 14; n++) begin
         term = udiv64(term, 64'd64 * 64'(n));
         if (n[0]) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      q  = pos - neg;
      q2 = mul_q62(q, q);
      e  = q;
      for (j = 0; j < SIG_HALF; j++) begin
         e42 = e >> 20;
         d   = (64'd1 << 42) + e42;
         np  = 64'd65535 << 42;
         nn  = 64'd65535 * e42;
         quo = udiv64(64'd2 * np + d, 64'd2 * d);
         rom[j] = quo[SIG_W-1:0];
         quo = udiv64(64'd2 * nn + d, 64'd2 * d);
         rom[SIG_DEPTH-1-j] = quo[SIG_W-1:0];
         e = mul_q62(e, q2);
      end
      return rom;
   endfunction

endpackage

// ===== rtl/wkvcr_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing but its parameters.
module wkvcr_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wkvcr_sig_rom.sv =====
`timescale 1ns / 1ps
// Receptance sigmoid ROM, 1024 x 16, registered read.
// Contents come from wkvcr_pkg::sig_rom_fill at elaboration.
module wkvcr_sig_rom
   import wkvcr_pkg::*;
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [SIG_AW-1:0] rd_addr,
   output logic [SIG_W-1:0]  rd_data
);

   localparam sig_rom_type SIG_TABLE = sig_rom_fill();

   logic [SIG_W-1:0] rd_data_ff;

   // Registered lookup, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SIG_TABLE[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wkvcr_datapath.sv =====
`timescale 1ns / 1ps
// Arithmetic of one step transaction: kv, decayed state, bonus term, gating.
// Uses wkvcr_pkg for widths, the control struct and saturation.
module wkvcr_datapath
   import wkvcr_pkg::*;
(
   input  logic                       clock,
   input  dp_ctl_type                 ctl,
   input  logic signed [15:0]         key_in,
   input  logic signed [15:0]         value_in,
   input  logic                       first_token,
   input  logic [STATE_W-1:0]         st_rdata,
   input  logic [COEF_W-1:0]          decay,
   input  logic signed [COEF_W-1:0]   bonus,
   input  logic [SIG_W-1:0]           sig,
   output logic [STATE_W-1:0]         p_next,
   output logic [STATE_W-1:0]         gated,
   output logic                       saturated
);

   logic signed [31:0] kv_ff;
   logic signed [31:0] kv_in;
   logic               first_ff;
   logic [35:0]        pp_lo_ff;
   logic [35:0]        pp_lo_in;
   logic signed [36:0] pp_hi_ff;
   logic signed [36:0] pp_hi_in;
   logic signed [47:0] bkv_ff;
   logic signed [47:0] bkv_in;
   logic [STATE_W-1:0] p_ff;
   logic [STATE_W-1:0] wkv_ff;
   logic               sat_ff;
   logic [35:0]        gl_ff;
   logic [35:0]        gl_in;
   logic signed [36:0] gh_ff;
   logic signed [36:0] gh_in;

   logic [STATE_W-1:0] prev;
   logic [56:0]        ap_sum;
   logic [STATE_W+1:0] p_raw;
   logic [STATE_W+1:0] wkv_raw;
   sat_type            p_sat;
   sat_type            wkv_sat;
   logic [56:0]        g_sum;

   // Products: kv at capture, split a*prev and b*kv in the multiply stage
   always_comb begin
      kv_in    = key_in * value_in;
      prev     = first_ff ? '0 : st_rdata;
      pp_lo_in = {20'd0, decay} * {16'd0, prev[19:0]};
      pp_hi_in = $signed({1'b0, decay}) * $signed(prev[STATE_W-1:20]);
      bkv_in   = bonus * kv_ff;
   end

   // Recurrence sum: floor(a*prev / 2^16) + kv, clipped
   always_comb begin
      ap_sum = {pp_hi_ff, 20'd0} + {21'd0, pp_lo_ff};
      p_raw  = {ap_sum[56], ap_sum[56:16]} + {{10{kv_ff[31]}}, kv_ff};
      p_sat  = sat40(p_raw);
      p_next = p_sat.val;
   end

   // wkv = p + floor(b*kv / 2^11), clipped; then split gate products
   always_comb begin
      wkv_raw = {{2{p_ff[STATE_W-1]}}, p_ff} + {{5{bkv_ff[47]}}, bkv_ff[47:11]};
      wkv_sat = sat40(wkv_raw);
      gl_in   = {20'd0, sig} * {16'd0, wkv_ff[19:0]};
      gh_in   = $signed({1'b0, sig}) * $signed(wkv_ff[STATE_W-1:20]);
   end

   // Gated result: floor(sig*wkv / 2^16) fits in 40 bits
   always_comb begin
      g_sum     = {gh_ff, 20'd0} + {21'd0, gl_ff};
      gated     = g_sum[55:16];
      saturated = sat_ff;
   end

   // Stage registers
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         kv_ff    <= kv_in;
         first_ff <= first_token;
      end
      if (ctl.mul) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         bkv_ff   <= bkv_in;
      end
      if (ctl.sum) begin
         p_ff   <= p_sat.val;
         sat_ff <= p_sat.clip;
      end
      if (ctl.wkv) begin
         wkv_ff <= wkv_sat.val;
         sat_ff <= sat_ff | wkv_sat.clip;
      end
      if (ctl.gate) begin
         gl_ff <= gl_in;
         gh_ff <= gh_in;
      end
   end

endmodule

// ===== rtl/wkv_channel_recurrence_top.sv =====
`timescale 1ns / 1ps
// Top level of the WKV channel recurrence: sequencer, state and coefficient
// RAMs, sigmoid ROM, datapath and result register. Uses wkvcr_pkg.
//
//  Channel | Ports                                  | Direction | Transaction
//  req     | req_valid, req_stall, req_* fields     | in        | load or step item
//  rsp     | rsp_valid, rsp_stall, rsp_* fields     | out       | one result per step
//
// A load transaction writes the coefficient RAM at acceptance.
// A step transaction runs through RAM/ROM read, multiply, state update and
// write-back, bonus add, gate multiply and result register; the registered state
// RAM read and the split 16x40 products set these steps.
// After reset a clearing pass over all CHANNELS entries initializes both RAMs; no
// transaction is accepted meanwhile. A stalled result holds the sequencer in
// its last step, while the result register frees the input for the next transaction.
module wkv_channel_recurrence_top
   import wkvcr_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [5:0]                req_channel,
   input  logic                      req_first_token,
   input  logic signed [15:0]        req_key_in,
   input  logic signed [15:0]        req_value_in,
   input  logic signed [15:0]        req_receptance_in,
   input  logic [15:0]               req_decay_load,
   input  logic signed [15:0]        req_bonus_load,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [5:0]                rsp_out_channel,
   output logic signed [39:0]        rsp_gated_out,
   output logic                      rsp_saturated
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WIDE_W = ADDR_W + 6;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNELS - 1);

   state_type           state_ff;
   state_type           state_in;
   logic [ADDR_W-1:0]   clr_cnt_ff;
   logic [ADDR_W-1:0]   clr_cnt_in;
   logic [ADDR_W-1:0]   ch_addr_ff;
   logic [5:0]          ch_ff;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [5:0]          rsp_channel_ff;
   logic [STATE_W-1:0]  rsp_gated_ff;
   logic                rsp_sat_ff;

   dp_ctl_type          ctl;
   logic                in_range;
   logic                load_out;
   logic                out_free;
   logic [WIDE_W-1:0]   ch_wide;
   logic [ADDR_W-1:0]   req_addr;

   logic                st_we;
   logic [ADDR_W-1:0]   st_waddr;
   logic [STATE_W-1:0]  st_wdata;
   logic [STATE_W-1:0]  st_rdata;
   logic                cf_we;
   logic [ADDR_W-1:0]   cf_waddr;
   logic [2*COEF_W-1:0] cf_wdata;
   logic [2*COEF_W-1:0] cf_rdata;
   logic [SIG_W-1:0]    sig;
   logic [STATE_W-1:0]  p_next;
   logic [STATE_W-1:0]  gated;
   logic                saturated;

   // Channel address and range check
   always_comb begin
      ch_wide  = {{ADDR_W{1'b0}}, req_channel};
      req_addr = ch_wide[ADDR_W-1:0];
      in_range = ch_wide < WIDE_W'(CHANNELS);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Sequencer: next state and stage enables
   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      ctl         = '0;
      req_stall   = 1'b1;
      load_out    = 1'b0;
      st_we       = 1'b0;
      st_waddr    = ch_addr_ff;
      st_wdata    = p_next;
      cf_we       = 1'b0;
      cf_waddr    = req_addr;
      cf_wdata    = {req_decay_load, req_bonus_load};
      unique case (state_ff)
         ST_CLEAR: begin
            st_we      = 1'b1;
            st_waddr   = clr_cnt_ff;
            st_wdata   = '0;
            cf_we      = 1'b1;
            cf_waddr   = clr_cnt_ff;
            cf_wdata   = {DECAY_RESET, BONUS_RESET};
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && in_range) begin
               if (req_cmd == CMD_STEP) begin
                  ctl.capture = 1'b1;
                  state_in    = ST_MUL;
               end else begin
                  cf_we = 1'b1;
               end
            end
         end
         ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            ctl.sum  = 1'b1;
            st_we    = 1'b1;
            state_in = ST_WKV;
         end
         ST_WKV: begin
            ctl.wkv  = 1'b1;
            state_in = ST_GATE;
         end
         ST_GATE: begin
            ctl.gate = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Channel of the step in flight
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         ch_addr_ff <= req_addr;
         ch_ff      <= req_channel;
      end
   end

   // Result register
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_channel_ff <= ch_ff;
         rsp_gated_ff   <= gated;
         rsp_sat_ff     <= saturated;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_gated_out   = rsp_gated_ff;
   assign rsp_saturated   = rsp_sat_ff;

   // Recurrence state RAM
   wkvcr_ram #(
      .WIDTH  (STATE_W),
      .DEPTH  (CHANNELS),
      .ADDR_W (ADDR_W)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (ctl.capture),
      .rd_addr (req_addr),
      .rd_data (st_rdata)
   );

   // Decay and bonus RAM, {decay, bonus} per entry
   wkvcr_ram #(
      .WIDTH  (2 * COEF_W),
      .DEPTH  (CHANNELS),
      .ADDR_W (ADDR_W)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (cf_we),
      .wr_addr (cf_waddr),
      .wr_data (cf_wdata),
      .rd_en   (ctl.capture),
      .rd_addr (req_addr),
      .rd_data (cf_rdata)
   );

   // Sigmoid lookup indexed by r >> 6
   wkvcr_sig_rom u_sig_rom (
      .clock   (clock),
      .rd_en   (ctl.capture),
      .rd_addr (req_receptance_in[15:6]),
      .rd_data (sig)
   );

   wkvcr_datapath u_datapath (
      .clock       (clock),
      .ctl         (ctl),
      .key_in      (req_key_in),
      .value_in    (req_value_in),
      .first_token (req_first_token),
      .st_rdata    (st_rdata),
      .decay       (cf_rdata[2*COEF_W-1:COEF_W]),
      .bonus       ($signed(cf_rdata[COEF_W-1:0])),
      .sig         (sig),
      .p_next      (p_next),
      .gated       (gated),
      .saturated   (saturated)
   );

   // A new result only comes out of the last step of the sequencer
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result register loaded outside the output step");

   // A blocked result keeps the sequencer waiting
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !out_free) |=> state_ff == ST_OUT)
      else $error("sequencer left the output step with the result register busy");

   // The clearing pass runs over every entry before inputs open
   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_cnt_ff != LAST_ADDR) |=> state_ff == ST_CLEAR)
      else $error("clearing pass ended early");

   // State write-back only in the update step or the clearing pass
   a_st_write: assert property (@(posedge clock) disable iff (reset)
      st_we |-> (state_ff == ST_SUM && $past(state_ff) == ST_MUL) || state_ff == ST_CLEAR)
      else $error("state RAM written out of sequence");

endmodule
